### rtl/cpro_pkg.sv
// cpro_pkg: shared types, constants and pixel functions for the clipped
// pixel raster op block. No dependencies.
package cpro_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM) + 1;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int COORD_W = 16;
    localparam int ADDR_W  = 24;
    localparam int PIX_W   = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [2:0] REG_DEST_PITCH  = 3'd4;
    localparam logic [2:0] REG_PIXEL_OP    = 3'd5;
    localparam logic [2:0] REG_BLEND_EN    = 3'd6;
    localparam logic [2:0] REG_KEY_EN      = 3'd7;

    localparam logic [2:0] OP_SRC    = 3'd1;
    localparam logic [2:0] OP_DEST   = 3'd2;
    localparam logic [2:0] OP_MIX75  = 3'd3;
    localparam logic [2:0] OP_INVERT = 3'd4;
    localparam logic [2:0] OP_AVG    = 3'd5;

    localparam logic [23:0] KEY_RGB      = 24'hFF00FF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [11:0]      clip_left;
        logic [DIM_W-1:0] clip_right;
        logic [11:0]      clip_top;
        logic [DIM_W-1:0] clip_bottom;
        logic [DIM_W-1:0] dest_pitch;
        logic [2:0]       pixel_op;
        logic             blend_enable;
        logic             color_key_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic [PIX_W-1:0]          src_pixel;
        logic [PIX_W-1:0]          dest_pixel;
        logic                      last_in;
    } t_in_item;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_address;
        logic [PIX_W-1:0]  pixel_out;
        logic              last_out;
    } t_out_item;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    function automatic logic [PIX_W-1:0] raster_op(input logic [PIX_W-1:0] s,
                                                   input logic [PIX_W-1:0] d,
                                                   input logic [2:0]       op);
        logic [PIX_W-1:0] mix;
        logic [PIX_W-1:0] avg;
        logic [9:0]       m;
        logic [8:0]       a;
        logic [PIX_W-1:0] res;
        mix = {ALPHA_OPAQUE, 24'd0};
        avg = {ALPHA_OPAQUE, 24'd0};
        for (int c = 0; c < 3; c++) begin
            m = 10'(3 * {2'd0, s[c*8 +: 8]}) + {2'd0, d[c*8 +: 8]};
            a = {1'b0, s[c*8 +: 8]} + {1'b0, d[c*8 +: 8]};
            mix[c*8 +: 8] = m[9:2];
            avg[c*8 +: 8] = a[8:1];
        end
        case (op)
            OP_SRC:    res = s;
            OP_DEST:   res = d;
            OP_MIX75:  res = mix;
            OP_INVERT: res = {ALPHA_OPAQUE, ~d[23:0]};
            OP_AVG:    res = avg;
            default:   res = '0;
        endcase
        return res;
    endfunction

endpackage

### rtl/cpro_regs.sv
// cpro_regs: APB-style configuration register file.
// Depends on cpro_pkg.
module cpro_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpro_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpro_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpro_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output cpro_pkg::t_cfg                o_cfg
);

    cpro_pkg::t_cfg r_cfg;
    cpro_pkg::t_cfg n_cfg;
    logic [2:0]     idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (idx)
                cpro_pkg::REG_CLIP_LEFT:   n_cfg.clip_left        = pwdata[11:0];
                cpro_pkg::REG_CLIP_RIGHT:  n_cfg.clip_right       = pwdata[12:0];
                cpro_pkg::REG_CLIP_TOP:    n_cfg.clip_top         = pwdata[11:0];
                cpro_pkg::REG_CLIP_BOTTOM: n_cfg.clip_bottom      = pwdata[12:0];
                cpro_pkg::REG_DEST_PITCH:  n_cfg.dest_pitch       = pwdata[12:0];
                cpro_pkg::REG_PIXEL_OP:    n_cfg.pixel_op         = pwdata[2:0];
                cpro_pkg::REG_BLEND_EN:    n_cfg.blend_enable     = pwdata[0];
                cpro_pkg::REG_KEY_EN:      n_cfg.color_key_enable = pwdata[0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left        <= '0;
            r_cfg.clip_right       <= cpro_pkg::DIM_W'(cpro_pkg::MAX_DIM);
            r_cfg.clip_top         <= '0;
            r_cfg.clip_bottom      <= cpro_pkg::DIM_W'(cpro_pkg::MAX_DIM);
            r_cfg.dest_pitch       <= cpro_pkg::DIM_W'(cpro_pkg::MAX_DIM);
            r_cfg.pixel_op         <= cpro_pkg::OP_SRC;
            r_cfg.blend_enable     <= 1'b1;
            r_cfg.color_key_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            cpro_pkg::REG_CLIP_LEFT:   prdata = 32'(r_cfg.clip_left);
            cpro_pkg::REG_CLIP_RIGHT:  prdata = 32'(r_cfg.clip_right);
            cpro_pkg::REG_CLIP_TOP:    prdata = 32'(r_cfg.clip_top);
            cpro_pkg::REG_CLIP_BOTTOM: prdata = 32'(r_cfg.clip_bottom);
            cpro_pkg::REG_DEST_PITCH:  prdata = 32'(r_cfg.dest_pitch);
            cpro_pkg::REG_PIXEL_OP:    prdata = 32'(r_cfg.pixel_op);
            cpro_pkg::REG_BLEND_EN:    prdata = 32'(r_cfg.blend_enable);
            cpro_pkg::REG_KEY_EN:      prdata = 32'(r_cfg.color_key_enable);
            default:                   prdata = '0;
        endcase
    end

endmodule

### rtl/cpro_pipe.sv
// cpro_pipe: three-stage pixel pipeline (clip test, multiply and raster op,
// address add and output register). Depends on cpro_pkg.
module cpro_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpro_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cpro_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cpro_pkg::t_out_item o_out_data
);

    typedef struct packed {
        logic                           in_win;
        logic                           keyed;
        logic [cpro_pkg::POS_W-1:0]     x;
        logic [cpro_pkg::POS_W-1:0]     y;
        logic [cpro_pkg::PIX_W-1:0]     src;
        logic [cpro_pkg::PIX_W-1:0]     dst;
        logic                           last;
    } t_s1;

    typedef struct packed {
        logic                           in_win;
        logic                           keyed;
        logic [cpro_pkg::POS_W-1:0]     x;
        logic [cpro_pkg::ADDR_W-1:0]    prod;
        logic [cpro_pkg::PIX_W-1:0]     pix;
        logic                           last;
    } t_s2;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    cpro_pkg::t_out_item r_out, n_out;

    logic [cpro_pkg::DIM_W-1:0] right_sat, bottom_sat, pitch_sat;
    logic                       x_ok, y_ok;
    logic [cpro_pkg::ADDR_W-1:0] addr;

    assign rdy3 = !r_v3 || !i_out_stall;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

    assign right_sat  = cpro_pkg::sat_dim(i_cfg.clip_right);
    assign bottom_sat = cpro_pkg::sat_dim(i_cfg.clip_bottom);
    assign pitch_sat  = cpro_pkg::sat_dim(i_cfg.dest_pitch);

    // stage 1: window test on the incoming beat
    always_comb begin
        x_ok = !i_in_data.dest_x[15]
            && (i_in_data.dest_x[14:0] >= 15'(i_cfg.clip_left))
            && (i_in_data.dest_x[14:0] < 15'(right_sat));
        y_ok = !i_in_data.dest_y[15]
            && (i_in_data.dest_y[14:0] >= 15'(i_cfg.clip_top))
            && (i_in_data.dest_y[14:0] < 15'(bottom_sat));
        n_s1.in_win = x_ok && y_ok;
        n_s1.keyed  = i_cfg.color_key_enable
                   && (i_in_data.src_pixel[23:0] == cpro_pkg::KEY_RGB);
        n_s1.x      = i_in_data.dest_x[cpro_pkg::POS_W-1:0];
        n_s1.y      = i_in_data.dest_y[cpro_pkg::POS_W-1:0];
        n_s1.src    = i_in_data.src_pixel;
        n_s1.dst    = i_in_data.dest_pixel;
        n_s1.last   = i_in_data.last_in;
    end

    // stage 2: row offset multiply and raster op
    always_comb begin
        n_s2.in_win = r_s1.in_win;
        n_s2.keyed  = r_s1.keyed;
        n_s2.x      = r_s1.x;
        n_s2.prod   = cpro_pkg::ADDR_W'({{cpro_pkg::DIM_W{1'b0}}, r_s1.y}
                      * {{cpro_pkg::POS_W{1'b0}}, pitch_sat});
        n_s2.pix    = i_cfg.blend_enable
                    ? cpro_pkg::raster_op(r_s1.src, r_s1.dst, i_cfg.pixel_op)
                    : r_s1.src;
        n_s2.last   = r_s1.last;
    end

    // stage 3: address add, clip and key masking
    always_comb begin
        addr = r_s2.prod + cpro_pkg::ADDR_W'(r_s2.x);
        n_out.write_enable = r_s2.in_win && !r_s2.keyed;
        n_out.dest_address = r_s2.in_win ? addr : '0;
        n_out.pixel_out    = n_out.write_enable ? r_s2.pix : '0;
        n_out.last_out     = r_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) r_s1  <= n_s1;
        if (rdy2 && r_v1)       r_s2  <= n_s2;
        if (rdy3 && r_v2)       r_out <= n_out;
    end

    a_s1_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && rdy2 |=> r_v2)
        else $error("stage 1 beat lost");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !rdy2 |=> r_v1 && $stable(r_s1))
        else $error("stage 1 beat changed while held");

    a_s2_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy3 |=> r_v3)
        else $error("stage 2 beat lost");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_out.write_enable |-> r_out.pixel_out == '0)
        else $error("suppressed pixel not zero");

endmodule

### rtl/clipped_pixel_raster_op.sv
// Clipped pixel raster op: an accepted input beat passes through a three-stage
// pipeline (clip test, y*pitch multiply with raster op, address add) to the
// result beat; throughput one beat per cycle while the output is not stalled.
// Reset empties the pipeline and restores every configuration register.
// Depends on cpro_pkg, cpro_regs and cpro_pipe.
module clipped_pixel_raster_op (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpro_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpro_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpro_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cpro_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cpro_pkg::t_out_item           o_out_data
);

    cpro_pkg::t_cfg cfg;

    cpro_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpro_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
